// ----- hdl/slec_pkg.sv -----
// ----------------------------------------------------------------------------
// slec_pkg
// Shared types and codes for the sorted list engine.
// ----------------------------------------------------------------------------
package slec_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_POP_MIN = 2'd1,
        CMD_POP_MAX = 2'd2,
        CMD_REMOVE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_DEL,
        S_DONE
    } eng_state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] item_value;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] removed_value;
        logic [4:0]  entry_count;
    } rsp_t;

endpackage

// ----- hdl/slec_ram.sv -----
// ----------------------------------------------------------------------------
// slec_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module slec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/slec_engine.sv -----
// ----------------------------------------------------------------------------
// slec_engine
// Sweep sequencer: reads the value RAM one entry per cycle and writes each
// entry back one place up (insert) or one place down (removal).
// ----------------------------------------------------------------------------
module slec_engine #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           req_valid,
    output logic           req_ready,
    input  slec_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output slec_pkg::rsp_t rsp
);
    import slec_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    eng_state_t             state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic                   found_reg, found_next;
    status_t                status_reg, status_next;
    logic [VALUE_WIDTH-1:0] removed_reg, removed_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

    logic [VALUE_WIDTH+31:0] req_val_ext;
    logic [VALUE_WIDTH-1:0]  req_val;
    logic [VALUE_WIDTH+31:0] rem_ext;
    logic [CW+4:0]           cnt_ext;
    logic [AW-1:0]           cnt_last;
    logic                    is_full, is_empty;
    logic                    rd_less, rd_match, hit, at_last, at_zero;

    slec_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_val_ext = {{VALUE_WIDTH{req.item_value[31]}}, req.item_value};
    assign req_val     = req_val_ext[VALUE_WIDTH-1:0];
    assign cnt_last    = AW'(cnt_reg - CW'(1));
    assign is_full     = (cnt_reg == CAP_CNT);
    assign is_empty    = (cnt_reg == '0);
    assign rd_less     = ($signed(ram_rdata) < $signed(val_reg));
    assign rd_match    = (cmd_reg == CMD_REMOVE) ? (ram_rdata == val_reg) : 1'b1;
    assign hit         = !found_reg && rd_match;
    assign at_last     = (addr_reg == cnt_last);
    assign at_zero     = (addr_reg == '0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    if (req.cmd == CMD_INSERT) begin
                        state_next = (is_full || is_empty) ? S_DONE : S_INS;
                    end else begin
                        state_next = is_empty ? S_DONE : S_DEL;
                    end
                end
            end
            S_INS: begin
                if (rd_less) begin
                    state_next = S_DONE;
                end else if (at_zero) begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                state_next = S_DONE;
            end
            S_DEL: begin
                if (at_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cnt_next     = cnt_reg;
        cmd_next     = cmd_reg;
        val_next     = val_reg;
        addr_next    = addr_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg + AW'(1);
        ram_wdata    = ram_rdata;
        ram_raddr    = addr_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    cmd_next     = req.cmd;
                    val_next     = req_val;
                    found_next   = 1'b0;
                    removed_next = '0;
                    status_next  = STAT_OK;
                    if (req.cmd == CMD_INSERT) begin
                        if (is_full) begin
                            status_next = STAT_FULL;
                        end else if (is_empty) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = req_val;
                            cnt_next  = cnt_reg + CW'(1);
                        end else begin
                            ram_raddr = cnt_last;
                            addr_next = cnt_last;
                        end
                    end else if (is_empty) begin
                        status_next = STAT_MISS;
                    end else begin
                        ram_raddr = (req.cmd == CMD_POP_MAX) ? cnt_last : '0;
                        addr_next = ram_raddr;
                    end
                end
            end
            S_INS: begin
                ram_we = 1'b1;
                if (rd_less) begin
                    ram_wdata = val_reg;
                    cnt_next  = cnt_reg + CW'(1);
                end else if (!at_zero) begin
                    ram_raddr = addr_reg - AW'(1);
                    addr_next = addr_reg - AW'(1);
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = val_reg;
                cnt_next  = cnt_reg + CW'(1);
            end
            S_DEL: begin
                ram_waddr = addr_reg - AW'(1);
                if (hit) begin
                    found_next   = 1'b1;
                    removed_next = ram_rdata;
                end else if (found_reg) begin
                    ram_we = 1'b1;
                end
                if (at_last) begin
                    if (found_reg || hit) begin
                        cnt_next = cnt_reg - CW'(1);
                    end else begin
                        status_next = STAT_MISS;
                    end
                end else begin
                    ram_raddr = addr_reg + AW'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        cmd_reg     <= cmd_next;
        val_reg     <= val_next;
        addr_reg    <= addr_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    assign rem_ext = {{32{removed_reg[VALUE_WIDTH-1]}}, removed_reg};
    assign cnt_ext = {5'b0, cnt_reg};

    assign req_ready         = (state_reg == S_IDLE);
    assign rsp_valid         = (state_reg == S_DONE);
    assign rsp.status        = status_reg;
    assign rsp.removed_value = rem_ext[31:0];
    assign rsp.entry_count   = cnt_ext[4:0];

endmodule

// ----- hdl/sorted_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_list_engine_unit
// Ordered list of signed values held in a RAM; insert, pop min/max, remove.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_valid / s_ready | s_cmd, s_item_value
//  m_      | out | m_valid / m_ready | m_status, m_removed_value, m_entry_count
//
// One request at a time; the RAM sweep is one entry per cycle.
// Insert sweeps from the tail down to the insert position; no sweep when empty or full.
// Pop max reads only the tail. Pop min / remove sweep the whole list. Empty list: no sweep.
// The result register frees the engine for the next request while m_ stalls.
// Reset empties the list at once; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_list_engine_unit #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    input  logic signed [31:0]   s_item_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic signed [31:0]   m_removed_value,
    output logic [4:0]           m_entry_count
);
    import slec_pkg::*;

    req_t  eng_req;
    rsp_t  eng_rsp;
    logic  eng_rsp_valid;
    logic  eng_rsp_ready;
    logic  m_valid_reg, m_valid_next;
    rsp_t  m_rsp_reg, m_rsp_next;

    assign eng_req.cmd        = cmd_t'(s_cmd);
    assign eng_req.item_value = s_item_value;

    slec_engine #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (eng_req),
        .rsp_valid (eng_rsp_valid),
        .rsp_ready (eng_rsp_ready),
        .rsp       (eng_rsp)
    );

    assign eng_rsp_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_rsp_next   = m_rsp_reg;
        if (eng_rsp_ready) begin
            m_valid_next = eng_rsp_valid;
            m_rsp_next   = eng_rsp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_rsp_reg <= m_rsp_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_rsp_reg.status;
    assign m_removed_value = m_rsp_reg.removed_value;
    assign m_entry_count   = m_rsp_reg.entry_count;

endmodule

// ----- hdl/slec_chk.sv -----
// ----------------------------------------------------------------------------
// slec_chk
// Port-level checks on the sorted list engine, bound to the top level.
// ----------------------------------------------------------------------------
module slec_chk #(
    parameter int CAPACITY    = 16
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [1:0]           m_status,
    input logic signed [31:0]   m_removed_value,
    input logic [4:0]           m_entry_count
);
    import slec_pkg::*;

    localparam logic [4:0] CAP_LOW = 5'(CAPACITY);

    // result held while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_removed_value) && $stable(m_entry_count))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_OK || m_status == STAT_MISS
            || m_status == STAT_FULL))
        else $error("bad status code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_removed_value == '0)
        else $error("removed value on failed request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_FULL |-> m_entry_count == CAP_LOW)
        else $error("full reported below capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(s_valid && s_ready) |-> !s_ready)
        else $error("request taken on back-to-back cycles");

endmodule

bind sorted_list_engine_unit slec_chk #(
    .CAPACITY    (CAPACITY)
) u_slec_chk (.*);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sorted_list_engine_unit. Requests are queued up front, sent
// with random gaps, and each accepted request is run through a queue-based
// model of the sorted list to get the expected response. Responses are taken
// under random back-pressure and compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import slec_pkg::*;

    localparam int LIST_DEPTH      = 16;
    localparam int RANDOM_REQUESTS = 1650;
    localparam int DRAIN_CYCLES    = 40;
    localparam int POOL_DEPTH      = 32;

    typedef struct {
        cmd_t               op;
        logic signed [31:0] value;
        int                 gap;
    } request_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic signed [31:0] s_item_value;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic signed [31:0] m_removed_value;
    logic [4:0]         m_entry_count;

    request_t           request_queue[$];
    rsp_t               expected_responses[$];
    logic signed [31:0] sorted_model[$];
    logic signed [31:0] value_pool[$];
    int                 mismatch_count = 0;
    int                 gap_left = 0;
    int                 stall_left = 0;
    int                 calm_left = 100;
    bit                 ready_calm = 1'b0;

    sorted_list_engine_unit #(
        .CAPACITY    (LIST_DEPTH),
        .VALUE_WIDTH (32)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_item_value    (s_item_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_entry_count   (m_entry_count)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(string msg);
        $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Applies one request to the list model and returns the response it owes.
    function automatic rsp_t list_response(cmd_t op, logic signed [31:0] value);
        rsp_t r;
        int   pos;
        r = '0;
        r.status = STAT_OK;
        pos = 0;
        case (op)
            CMD_INSERT: begin
                if (sorted_model.size() >= LIST_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    while (pos < sorted_model.size() && sorted_model[pos] < value) pos++;
                    sorted_model.insert(pos, value);
                end
            end
            CMD_POP_MIN: begin
                if (sorted_model.size() == 0) r.status = STAT_MISS;
                else r.removed_value = sorted_model.pop_front();
            end
            CMD_POP_MAX: begin
                if (sorted_model.size() == 0) r.status = STAT_MISS;
                else r.removed_value = sorted_model.pop_back();
            end
            default: begin
                while (pos < sorted_model.size() && sorted_model[pos] != value) pos++;
                if (pos < sorted_model.size()) begin
                    r.removed_value = sorted_model[pos];
                    sorted_model.delete(pos);
                end else begin
                    r.status = STAT_MISS;
                end
            end
        endcase
        r.entry_count = 5'(sorted_model.size());
        return r;
    endfunction

    task automatic add_request(cmd_t op, logic signed [31:0] value, bit no_gap);
        request_t req;
        req.op    = op;
        req.value = value;
        req.gap   = no_gap ? 0 : pick_gap();
        request_queue.push_back(req);
        if (op == CMD_INSERT) begin
            value_pool.push_back(value);
            if (value_pool.size() > POOL_DEPTH) void'(value_pool.pop_front());
        end
    endtask

    function automatic logic signed [31:0] draw_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $signed($urandom_range(0, 8)) - 4;
        if (r < 50) begin
            case ($urandom_range(0, 4))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0000_0000;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        return $signed($urandom());
    endfunction

    // Request driver
    always @(posedge aclk) begin : driver
        request_t next_req;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_responses.push_back(list_response(cmd_t'(s_cmd), s_item_value));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (request_queue.size() > 0) begin
                    next_req     = request_queue.pop_front();
                    s_valid      <= 1'b1;
                    s_cmd        <= next_req.op;
                    s_item_value <= next_req.value;
                    gap_left     <= next_req.gap;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor
    always @(posedge aclk) begin : monitor
        rsp_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_responses.size() == 0) begin
                    report_mismatch($sformatf("unexpected response, status %0d count %0d",
                                              m_status, m_entry_count));
                end else begin
                    want = expected_responses.pop_front();
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_status, want.status));
                    if (m_removed_value !== want.removed_value)
                        report_mismatch($sformatf("removed_value %0d, expected %0d",
                                                  m_removed_value,
                                                  $signed(want.removed_value)));
                    if (m_entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  m_entry_count, want.entry_count));
                end
                if (calm_left == 0) begin
                    ready_calm <= !ready_calm;
                    calm_left  <= $urandom_range(50, 150);
                end else begin
                    calm_left <= calm_left - 1;
                end
            end
            if (stall_left > 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!ready_calm && $urandom_range(0, 99) < 25) begin
                m_ready    <= 1'b0;
                stall_left <= pick_gap();
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int   issued;
        int   burst_len;
        int   bias;
        int   insert_pct;
        int   r;
        bit   quiet;
        cmd_t op;
        logic signed [31:0] value;

        aresetn      = 1'b0;

        // empty list
        add_request(CMD_POP_MIN, 32'sd9, 1'b0);
        add_request(CMD_POP_MAX, -32'sd9, 1'b0);
        add_request(CMD_REMOVE, 32'sd5, 1'b0);
        // extremes and a duplicate
        add_request(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
        add_request(CMD_INSERT, 32'sh8000_0000, 1'b0);
        add_request(CMD_INSERT, 32'sd0, 1'b0);
        add_request(CMD_INSERT, -32'sd1, 1'b0);
        add_request(CMD_INSERT, 32'sd0, 1'b0);
        add_request(CMD_INSERT, 32'sd5, 1'b0);
        add_request(CMD_REMOVE, 32'sd7, 1'b0);
        add_request(CMD_REMOVE, 32'sd0, 1'b0);
        add_request(CMD_POP_MIN, 32'sd0, 1'b0);
        add_request(CMD_POP_MAX, 32'sd0, 1'b0);
        // fill at the head until one insert is refused
        for (int i = 0; i < LIST_DEPTH - 2; i++) begin
            add_request(CMD_INSERT, -32'sd100 - 32'(7 * i), 1'b0);
        end
        add_request(CMD_REMOVE, 32'sd12345, 1'b0);

        issued = 0;
        while (issued < RANDOM_REQUESTS) begin
            burst_len = $urandom_range(15, 50);
            bias      = $urandom_range(0, 2);
            quiet     = ($urandom_range(0, 4) == 0);
            insert_pct = (bias == 0) ? 75 : (bias == 1) ? 20 : 50;
            repeat (burst_len) begin
                value = draw_value();
                if ($urandom_range(0, 99) < insert_pct) begin
                    op = CMD_INSERT;
                end else begin
                    r = $urandom_range(0, 3);
                    op = (r == 0) ? CMD_POP_MIN : (r == 1) ? CMD_POP_MAX : CMD_REMOVE;
                    if (op == CMD_REMOVE && value_pool.size() > 0 && $urandom_range(0, 99) < 70)
                        value = value_pool[$urandom_range(0, value_pool.size() - 1)];
                end
                add_request(op, value, quiet);
                issued++;
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_queue.size() != 0 || s_valid || expected_responses.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_responses.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived",
                                      expected_responses.size()));
        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
